[rtl/sksq_pkg.sv]
// Package for the stable key sort queue: sizes, status codes, sequencer states
// and the circular address helper. No dependencies.
`timescale 1ns / 1ps

package sksq_pkg;

  localparam int CAPACITY  = 1024;
  localparam int KEY_BITS  = 20;
  localparam int WORD_BITS = 56;
  localparam int ADDR_W    = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int SUM_W     = CNT_W + 1;
  localparam int REC_W     = KEY_BITS + WORD_BITS;
  localparam int IN_DATA_W  = ((REC_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((REC_W + CNT_W + 7) / 8) * 8;

  localparam logic [1:0] STAT_LOADED  = 2'd0;
  localparam logic [1:0] STAT_DROPPED = 2'd1;
  localparam logic [1:0] STAT_GIVEN   = 2'd2;
  localparam logic [1:0] STAT_EMPTY   = 2'd3;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_PULL = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SEARCH = 5'b00010,
    ST_PLACE  = 5'b00100,
    ST_PULL   = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  // Physical RAM address of a logical position counted from the head.
  function automatic logic [ADDR_W-1:0] phys_addr(input logic [ADDR_W-1:0] head,
                                                  input logic [CNT_W-1:0] idx);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(head) + SUM_W'(idx);
    if (sum >= SUM_W'(CAPACITY)) begin
      sum = sum - SUM_W'(CAPACITY);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

[rtl/sksq_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
`timescale 1ns / 1ps

module sksq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/stable_key_sort_queue_top.sv]
// Stable key sort queue: a circular record store in one RAM, kept sorted by a
// sequencer that moves one record per cycle. Depends on sksq_pkg and sksq_ram.
// A pull takes the head record in ST_PULL; a load shifts each stored record with a
// key greater than the new key up one place in ST_SEARCH, then writes the new record.
// One beat at a time; the RAM's single read and write port moves one record per
// cycle during an insert. A dropped load or an empty pull goes straight to ST_DONE.
// Reset clears the record count, head pointer and output valid; RAM contents are
// left as they are, since only positions below the record count are ever used.
`timescale 1ns / 1ps

module stable_key_sort_queue_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // key [19:0], word [75:20], zero fill above.
  input  logic [sksq_pkg::IN_DATA_W-1:0]    in_tdata,
  // mode [0].
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_key [19:0], out_word [75:20], remaining [86:76], zero fill above.
  output logic [sksq_pkg::OUT_DATA_W-1:0]   out_tdata,
  // status [1:0].
  output logic [1:0]                        out_tuser
);

  import sksq_pkg::*;

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [ADDR_W-1:0]     head_r, head_nxt;
  logic [CNT_W-1:0]      idx_r, idx_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [WORD_BITS-1:0]  word_r, word_nxt;
  logic [1:0]            res_status_r, res_status_nxt;
  logic [KEY_BITS-1:0]   res_key_r, res_key_nxt;
  logic [WORD_BITS-1:0]  res_word_r, res_word_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [1:0]            out_user_r, out_user_nxt;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [REC_W-1:0]      ram_wdata;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [REC_W-1:0]      ram_rdata;
  logic [CNT_W-1:0]      rd_idx;
  logic                  in_fire;
  logic [KEY_BITS-1:0]   rd_key;

  sksq_ram #(
    .WIDTH (REC_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign rd_key     = ram_rdata[KEY_BITS-1:0];
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    head_nxt       = head_r;
    idx_nxt        = idx_r;
    key_nxt        = key_r;
    word_nxt       = word_r;
    res_status_nxt = res_status_r;
    res_key_nxt    = res_key_r;
    res_word_nxt   = res_word_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;
    ram_we         = 1'b0;
    ram_waddr      = phys_addr(head_r, idx_r);
    ram_wdata      = {word_r, key_r};
    rd_idx         = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (count_r != '0) begin
          rd_idx = count_r - CNT_W'(1);
        end
        if (in_tuser == MODE_PULL) begin
          rd_idx = '0;
        end
        if (in_fire) begin
          key_nxt      = in_tdata[KEY_BITS-1:0];
          word_nxt     = in_tdata[REC_W-1:KEY_BITS];
          res_key_nxt  = '0;
          res_word_nxt = '0;
          if (in_tuser == MODE_LOAD) begin
            if (count_r >= CNT_W'(CAPACITY)) begin
              res_status_nxt = STAT_DROPPED;
              state_nxt      = ST_DONE;
            end else if (count_r == '0) begin
              idx_nxt   = '0;
              state_nxt = ST_PLACE;
            end else begin
              idx_nxt   = count_r;
              state_nxt = ST_SEARCH;
            end
          end else begin
            if (count_r == '0) begin
              res_status_nxt = STAT_EMPTY;
              state_nxt      = ST_DONE;
            end else begin
              state_nxt = ST_PULL;
            end
          end
        end
      end
      ST_SEARCH: begin
        if (idx_r >= CNT_W'(2)) begin
          rd_idx = idx_r - CNT_W'(2);
        end
        ram_we = 1'b1;
        if (rd_key > key_r) begin
          ram_wdata = ram_rdata;
          idx_nxt   = idx_r - CNT_W'(1);
          if (idx_r == CNT_W'(1)) begin
            state_nxt = ST_PLACE;
          end
        end else begin
          res_status_nxt = STAT_LOADED;
          count_nxt      = count_r + CNT_W'(1);
          state_nxt      = ST_DONE;
        end
      end
      ST_PLACE: begin
        ram_we         = 1'b1;
        res_status_nxt = STAT_LOADED;
        count_nxt      = count_r + CNT_W'(1);
        state_nxt      = ST_DONE;
      end
      ST_PULL: begin
        res_status_nxt = STAT_GIVEN;
        res_key_nxt    = rd_key;
        res_word_nxt   = ram_rdata[REC_W-1:KEY_BITS];
        head_nxt       = phys_addr(head_r, CNT_W'(1));
        count_nxt      = count_r - CNT_W'(1);
        state_nxt      = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = res_status_r;
          out_data_nxt  = OUT_DATA_W'({count_r, res_word_r, res_key_r});
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    ram_raddr = phys_addr(head_r, rd_idx);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    key_r        <= key_nxt;
    word_r       <= word_nxt;
    res_status_r <= res_status_nxt;
    res_key_r    <= res_key_nxt;
    res_word_r   <= res_word_nxt;
    out_data_r   <= out_data_nxt;
    out_user_r   <= out_user_nxt;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("record count exceeds capacity");

  a_search_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) |-> (idx_r != '0))
    else $error("insert search reached position zero without placing");

  a_pull_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PULL) |=> (state_r == ST_DONE) && (count_r == $past(count_r) - CNT_W'(1)))
    else $error("pull did not remove exactly one record");

  a_load_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PLACE) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("placed record did not raise the count");
`endif

endmodule
